// File: src/bba_pkg.sv
package bba_pkg;

  localparam int MAX_ORDER    = 20;
  localparam int MIN_ORDER    = 6;
  localparam int HEADER_BYTES = 32;

  localparam int ADDR_BITS  = 20;
  localparam int BYTES_BITS = 21;
  localparam int TOTAL_BITS = BYTES_BITS + 1;
  localparam int ORD_BITS   = 5;

  // tree nodes 1..2^(MAX-MIN+1)-1, packed 32 to a memory row
  localparam int NODE_BITS = MAX_ORDER - MIN_ORDER + 1;
  localparam int IDX_BITS  = 5;
  localparam int WORD_BITS = 1 << IDX_BITS;
  localparam int ROW_BITS  = NODE_BITS - IDX_BITS;
  localparam int ROWS      = 1 << ROW_BITS;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [ROW_BITS-1:0]  row_idx_t;
  typedef logic [ORD_BITS-1:0]  order_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic                  action;
    logic [BYTES_BITS-1:0] request_bytes;
    logic [ADDR_BITS-1:0]  release_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] granted_address;
    logic                 status;
  } rsp_t;

  // one memory row: allocated-block marks and free-block marks for 32 nodes
  typedef struct packed {
    logic [WORD_BITS-1:0] alloc_bits;
    logic [WORD_BITS-1:0] free_bits;
  } row_t;

  localparam int ROW_W = 2 * WORD_BITS;

endpackage

// File: src/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/bba_scan.sv
// First free node of one order within a memory row. Orders whose nodes
// share row 0 are picked out by a mask.
module bba_scan (
  input  logic [bba_pkg::WORD_BITS-1:0] word,
  input  logic [bba_pkg::ORD_BITS-1:0]  lvl,
  output logic                          hit,
  output logic [bba_pkg::IDX_BITS-1:0]  idx
);

  logic [bba_pkg::WORD_BITS-1:0] mask;
  logic [bba_pkg::WORD_BITS-1:0] cand;

  always_comb begin
    for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
      if (lvl >= bba_pkg::ORD_BITS'(bba_pkg::IDX_BITS)) begin
        mask[i] = 1'b1;
      end else begin
        mask[i] = (i >= (1 << lvl)) && (i < (2 << lvl));
      end
    end
    cand = word & mask;
    hit  = |cand;
    idx  = '0;
    for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = bba_pkg::IDX_BITS'(i);
      end
    end
  end

endmodule

// File: src/buddy_block_allocator.sv
// channel   ports                 handshake
// request   start, request        taken when start && !busy
// response  done, result          one-cycle strobe, no backpressure
//
// One request at a time; busy is high until its result strobes.
// Allocate: size rounding, then a read and a check per bitmap row
// scanned, a split step, read and write per split level, then a read and write to mark the block.
// Free: a read and a check per order probed and per merge level, then a read and write to mark.
// All bitmap accesses go through the single-port node bitmap memory.
// After reset a clearing pass over all 1024 bitmap rows runs with busy high.
module buddy_block_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bba_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output bba_pkg::rsp_t result
);

  typedef enum logic [15:0] {
    S_INIT   = 16'h0001,
    S_IDLE   = 16'h0002,
    S_ASIZE  = 16'h0004,
    S_ARD    = 16'h0008,
    S_ACHK   = 16'h0010,
    S_SPL    = 16'h0020,
    S_SPLRD  = 16'h0040,
    S_SPLWR  = 16'h0080,
    S_SETARD = 16'h0100,
    S_SETAWR = 16'h0200,
    S_FRD    = 16'h0400,
    S_FCHK   = 16'h0800,
    S_MRD    = 16'h1000,
    S_MCHK   = 16'h2000,
    S_SETFRD = 16'h4000,
    S_SETFWR = 16'h8000
  } state_t;

  localparam bba_pkg::order_t MAXO = bba_pkg::ORD_BITS'(bba_pkg::MAX_ORDER);
  localparam bba_pkg::order_t MINO = bba_pkg::ORD_BITS'(bba_pkg::MIN_ORDER);
  localparam bba_pkg::addr_t  HDR  = bba_pkg::ADDR_BITS'(bba_pkg::HEADER_BYTES);

  state_t                           state;
  state_t                           state_next;
  bba_pkg::row_idx_t                clr_row;
  bba_pkg::row_idx_t                scan_row;
  bba_pkg::order_t                  k;
  bba_pkg::order_t                  need;
  bba_pkg::node_t                   node;
  bba_pkg::addr_t                   off;
  logic                             bad;
  logic [bba_pkg::TOTAL_BITS-1:0]   total;

  logic                             ram_we;
  bba_pkg::row_idx_t                ram_addr;
  bba_pkg::row_t                    wrow;
  bba_pkg::row_t                    rrow;
  logic [bba_pkg::ROW_W-1:0]        rdata;

  bba_pkg::order_t                  lvl;
  bba_pkg::order_t                  lvl_up;
  logic                             hit;
  logic [bba_pkg::IDX_BITS-1:0]     hit_idx;
  bba_pkg::node_t                   found;
  bba_pkg::node_t                   lo_node;
  bba_pkg::node_t                   fnode;
  bba_pkg::node_t                   bnode;
  bba_pkg::node_t                   snode;
  logic                             aligned;
  logic [bba_pkg::TOTAL_BITS-1:0]   pow;

  function automatic bba_pkg::row_idx_t first_row(input bba_pkg::order_t l);
    if (l >= bba_pkg::ORD_BITS'(bba_pkg::IDX_BITS)) begin
      return bba_pkg::ROW_BITS'(1) << (l - bba_pkg::ORD_BITS'(bba_pkg::IDX_BITS));
    end
    return '0;
  endfunction

  function automatic bba_pkg::row_idx_t last_row(input bba_pkg::order_t l);
    logic [bba_pkg::ROW_BITS:0] t;
    t = '0;
    if (l >= bba_pkg::ORD_BITS'(bba_pkg::IDX_BITS)) begin
      t = ((bba_pkg::ROW_BITS + 1)'(1) << (l - bba_pkg::ORD_BITS'(bba_pkg::IDX_BITS - 1)))
          - (bba_pkg::ROW_BITS + 1)'(1);
    end
    return t[bba_pkg::ROW_BITS-1:0];
  endfunction

  function automatic bba_pkg::row_idx_t row_of(input bba_pkg::node_t n);
    return n[bba_pkg::NODE_BITS-1:bba_pkg::IDX_BITS];
  endfunction

  bba_ram #(
    .WIDTH(bba_pkg::ROW_W),
    .DEPTH(bba_pkg::ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(wrow),
    .rdata(rdata)
  );

  assign rrow = bba_pkg::row_t'(rdata);

  bba_scan u_scan (
    .word(rrow.free_bits),
    .lvl (lvl),
    .hit (hit),
    .idx (hit_idx)
  );

  assign lvl     = MAXO - k;
  assign lvl_up  = MAXO - (k + bba_pkg::ORD_BITS'(1));
  assign found   = {scan_row, hit_idx};
  assign lo_node = bba_pkg::NODE_BITS'(1) << lvl;
  assign fnode   = lo_node | bba_pkg::NODE_BITS'(off >> k);
  assign bnode   = node ^ bba_pkg::NODE_BITS'(1);
  assign snode   = node | bba_pkg::NODE_BITS'(1);
  assign aligned = (off & ~({bba_pkg::ADDR_BITS{1'b1}} << k)) == '0;
  assign pow     = bba_pkg::TOTAL_BITS'(1) << need;
  assign busy    = (state != S_IDLE);

  // memory address and write data
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = row_of(node);
    wrow     = rrow;
    unique case (state)
      S_INIT: begin
        ram_we   = 1'b1;
        ram_addr = clr_row;
        wrow     = '0;
        if (clr_row == '0) begin
          wrow.free_bits[1] = 1'b1;
        end
      end
      S_ARD: ram_addr = scan_row;
      S_ACHK: begin
        ram_addr = scan_row;
        if (hit) begin
          ram_we = 1'b1;
          wrow.free_bits[hit_idx] = 1'b0;
        end
      end
      S_SPLRD: ram_addr = row_of(snode);
      S_SPLWR: begin
        ram_addr = row_of(snode);
        ram_we   = 1'b1;
        wrow.free_bits[snode[bba_pkg::IDX_BITS-1:0]] = 1'b1;
      end
      S_SETAWR: begin
        ram_we = 1'b1;
        wrow.alloc_bits[node[bba_pkg::IDX_BITS-1:0]] = 1'b1;
      end
      S_FRD: ram_addr = row_of(fnode);
      S_FCHK: begin
        if (rrow.alloc_bits[node[bba_pkg::IDX_BITS-1:0]]) begin
          ram_we = 1'b1;
          wrow.alloc_bits[node[bba_pkg::IDX_BITS-1:0]] = 1'b0;
        end
      end
      S_MRD: ram_addr = row_of(bnode);
      S_MCHK: begin
        ram_addr = row_of(bnode);
        if (rrow.free_bits[bnode[bba_pkg::IDX_BITS-1:0]]) begin
          ram_we = 1'b1;
          wrow.free_bits[bnode[bba_pkg::IDX_BITS-1:0]] = 1'b0;
        end
      end
      S_SETFWR: begin
        ram_we = 1'b1;
        wrow.free_bits[node[bba_pkg::IDX_BITS-1:0]] = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_INIT: clr_row <= clr_row + bba_pkg::ROW_BITS'(1);
        S_IDLE: begin
          if (start) begin
            total <= bba_pkg::TOTAL_BITS'(request.request_bytes) + bba_pkg::TOTAL_BITS'(HDR);
            need  <= MINO;
            k     <= MINO;
            bad   <= request.release_address < HDR;
            off   <= request.release_address - HDR;
          end
        end
        S_ASIZE: begin
          if (need > MAXO) begin
            done   <= 1'b1;
            result <= '{granted_address: '0, status: bba_pkg::ST_FAIL};
          end else if (pow < total) begin
            need <= need + bba_pkg::ORD_BITS'(1);
          end else begin
            k        <= need;
            scan_row <= first_row(MAXO - need);
          end
        end
        S_ACHK: begin
          if (hit) begin
            node <= found;
            off  <= {{(bba_pkg::ADDR_BITS - bba_pkg::NODE_BITS){1'b0}}, found - lo_node} << k;
          end else if (scan_row == last_row(lvl)) begin
            if (k == MAXO) begin
              done   <= 1'b1;
              result <= '{granted_address: '0, status: bba_pkg::ST_FAIL};
            end else begin
              k        <= k + bba_pkg::ORD_BITS'(1);
              scan_row <= first_row(lvl_up);
            end
          end else begin
            scan_row <= scan_row + bba_pkg::ROW_BITS'(1);
          end
        end
        S_SPL: begin
          if (k > need) begin
            k    <= k - bba_pkg::ORD_BITS'(1);
            node <= node << 1;
          end
        end
        S_SETAWR: begin
          done   <= 1'b1;
          result <= '{granted_address: off + HDR, status: bba_pkg::ST_OK};
        end
        S_FRD: begin
          if (bad || !aligned || k > MAXO) begin
            done   <= 1'b1;
            result <= '{granted_address: '0, status: bba_pkg::ST_FAIL};
          end else begin
            node <= fnode;
          end
        end
        S_FCHK: begin
          if (!rrow.alloc_bits[node[bba_pkg::IDX_BITS-1:0]]) begin
            k <= k + bba_pkg::ORD_BITS'(1);
          end
        end
        S_MCHK: begin
          // buddy free: absorb it and climb one level
          if (rrow.free_bits[bnode[bba_pkg::IDX_BITS-1:0]]) begin
            node <= node >> 1;
            k    <= k + bba_pkg::ORD_BITS'(1);
          end
        end
        S_SETFWR: begin
          done   <= 1'b1;
          result <= '{granted_address: '0, status: bba_pkg::ST_OK};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (clr_row == bba_pkg::ROW_BITS'(bba_pkg::ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = (request.action == bba_pkg::ACT_FREE) ? S_FRD : S_ASIZE;
        end
      end
      S_ASIZE: begin
        if (need > MAXO) begin
          state_next = S_IDLE;
        end else if (!(pow < total)) begin
          state_next = S_ARD;
        end
      end
      S_ARD: state_next = S_ACHK;
      S_ACHK: begin
        if (hit) begin
          state_next = S_SPL;
        end else if (scan_row == last_row(lvl) && k == MAXO) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_ARD;
        end
      end
      S_SPL:    state_next = (k > need) ? S_SPLRD : S_SETARD;
      S_SPLRD:  state_next = S_SPLWR;
      S_SPLWR:  state_next = S_SPL;
      S_SETARD: state_next = S_SETAWR;
      S_SETAWR: state_next = S_IDLE;
      S_FRD: begin
        state_next = (bad || !aligned || k > MAXO) ? S_IDLE : S_FCHK;
      end
      S_FCHK: begin
        state_next = rrow.alloc_bits[node[bba_pkg::IDX_BITS-1:0]] ? S_MRD : S_FRD;
      end
      S_MRD: state_next = (k == MAXO) ? S_SETFRD : S_MCHK;
      S_MCHK: begin
        state_next = rrow.free_bits[bnode[bba_pkg::IDX_BITS-1:0]] ? S_MRD : S_SETFRD;
      end
      S_SETFRD: state_next = S_SETFWR;
      S_SETFWR: state_next = S_IDLE;
      default:  state_next = S_INIT;
    endcase
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bba_pkg::*;

  localparam int POOL_BYTES = 1 << MAX_ORDER;
  localparam int UNITS      = 1 << (MAX_ORDER - MIN_ORDER);
  localparam int NODES      = 2 * UNITS;
  localparam int WATCHDOG   = 200000;

  logic  clk;
  logic  rst;
  logic  start;
  req_t  request;
  logic  busy;
  logic  done;
  rsp_t  result;

  buddy_block_allocator DUT (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // predictor state
  bit     pool_free [NODES];
  order_t unit_ord  [UNITS];
  rsp_t   expected_words[$];
  addr_t  live_blocks[$];
  int     errors;
  int     idle_pct;
  int     quiet_cycles;

  task automatic pool_reset();
    foreach (pool_free[i]) pool_free[i] = 0;
    pool_free[1] = 1;
    foreach (unit_ord[i]) unit_ord[i] = order_t'(MAX_ORDER);
  endtask

  function automatic void set_orders(longint off, int k);
    for (longint u = 0; u < (longint'(1) << (k - MIN_ORDER)); u++)
      unit_ord[(off >> MIN_ORDER) + u] = order_t'(k);
  endfunction

  function automatic rsp_t predict_alloc(logic [BYTES_BITS-1:0] nbytes);
    rsp_t   r;
    longint total, node, off;
    int     need, k;
    bit     found;
    r = '{granted_address: '0, status: ST_FAIL};
    total = longint'(nbytes) + HEADER_BYTES;
    need = 0;
    found = 0;
    node = 0;
    while ((longint'(1) << need) < total) need++;
    if (need < MIN_ORDER) need = MIN_ORDER;
    if (need > MAX_ORDER) return r;
    for (k = need; k <= MAX_ORDER; k++) begin
      for (longint n = longint'(1) << (MAX_ORDER - k);
           n < (longint'(2) << (MAX_ORDER - k)); n++)
        if (pool_free[n]) begin
          node = n; found = 1; break;
        end
      if (found) break;
    end
    if (!found) return r;
    off = (node - (longint'(1) << (MAX_ORDER - k))) << k;
    pool_free[node] = 0;
    while (k > need) begin
      k--;
      node = 2 * node;
      pool_free[node + 1] = 1;
      set_orders(off + (longint'(1) << k), k);
    end
    set_orders(off, k);
    r.granted_address = addr_t'(off + HEADER_BYTES);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic rsp_t predict_free(addr_t addr);
    rsp_t   r;
    longint off, node;
    int     k;
    r = '{granted_address: '0, status: ST_FAIL};
    if (addr < HEADER_BYTES) return r;
    off = longint'(addr) - HEADER_BYTES;
    if (off >= POOL_BYTES) return r;
    if (off & ((longint'(1) << MIN_ORDER) - 1)) return r;
    k = unit_ord[off >> MIN_ORDER];
    if (k < MIN_ORDER || k > MAX_ORDER) return r;
    if (off & ((longint'(1) << k) - 1)) return r;
    node = (longint'(1) << (MAX_ORDER - k)) + (off >> k);
    if (pool_free[node]) return r;
    while (k < MAX_ORDER && pool_free[node ^ 1]) begin
      pool_free[node ^ 1] = 0;
      node >>= 1;
      off &= ~(longint'(1) << k);
      k++;
    end
    pool_free[node] = 1;
    set_orders(off, k);
    r.status = ST_OK;
    return r;
  endfunction

  // send one word and queue its expected result
  task automatic send_word(logic act, logic [BYTES_BITS-1:0] nbytes, addr_t raddr);
    req_t w;
    rsp_t e;
    w = '{action: act, request_bytes: nbytes, release_address: raddr};
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start   <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    if (act == ACT_ALLOC) begin
      e = predict_alloc(nbytes);
      if (e.status == ST_OK) live_blocks.push_back(e.granted_address);
    end else begin
      e = predict_free(raddr);
      if (e.status == ST_OK)
        foreach (live_blocks[i])
          if (live_blocks[i] == raddr) begin
            live_blocks.delete(i); break;
          end
    end
    expected_words.push_back(e);
    // start has dropped; the next word asserts it again after a random idle gap set by idle_pct
    @(posedge clk);
  endtask

  task automatic alloc_word(logic [BYTES_BITS-1:0] nbytes);
    send_word(ACT_ALLOC, nbytes, addr_t'($urandom));
  endtask

  task automatic free_word(addr_t a);
    send_word(ACT_FREE, BYTES_BITS'($urandom), a);
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic free_all_live();
    while (live_blocks.size() != 0)
      free_word(live_blocks[$urandom_range(live_blocks.size() - 1)]);
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (result.granted_address !== e.granted_address) begin
          $display("%0t: granted_address expected %h actual %h",
                   $time, e.granted_address, result.granted_address);
          errors++;
        end
        if (result.status !== e.status) begin
          $display("%0t: status expected %b actual %b", $time, e.status, result.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_extremes();
    alloc_word('0);
    alloc_word(BYTES_BITS'(POOL_BYTES));
    alloc_word(BYTES_BITS'(POOL_BYTES - HEADER_BYTES));
    alloc_word({BYTES_BITS{1'b1}});
    alloc_word(BYTES_BITS'(33));
    alloc_word(BYTES_BITS'(32));
    free_word('0);
    free_word(addr_t'(HEADER_BYTES - 1));
    free_word({ADDR_BITS{1'b1}});
    free_word(addr_t'(HEADER_BYTES + 1));
    free_word(addr_t'(HEADER_BYTES + 64));
    free_word(addr_t'(HEADER_BYTES + 128));
    free_word(addr_t'(HEADER_BYTES + 128));
    free_all_live();
    // whole pool in one block, then nothing left
    alloc_word(BYTES_BITS'(POOL_BYTES - HEADER_BYTES));
    alloc_word('0);
    free_all_live();
    drain();
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        case ($urandom_range(3))
          0: alloc_word(BYTES_BITS'($urandom_range(200)));
          1: alloc_word(BYTES_BITS'($urandom_range(4096)));
          2: alloc_word(BYTES_BITS'($urandom_range(65536)));
          default: alloc_word(BYTES_BITS'($urandom));
        endcase
      end else if (r < 85 && live_blocks.size() != 0)
        free_word(live_blocks[$urandom_range(live_blocks.size() - 1)]);
      else if (r < 92)
        free_word(addr_t'($urandom));
      else
        free_word(addr_t'(HEADER_BYTES + ($urandom_range(UNITS - 1) << MIN_ORDER)));
      if (i % 200 == 199) drain();
    end
    free_all_live();
    drain();
  endtask

  initial begin
    errors   = 0;
    idle_pct = 9;
    start    = 1'b0;
    request  = '0;
    rst      = 1'b1;
    pool_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random(700);
    idle_pct = 47;
    test_random(650);
    idle_pct = 0;
    test_random(650);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
